[rtl/core/tkp_pkg.sv]
// Shared types and constants for the top-K peak tracker.
// Used by tkp_cell, tkp_stats and top_k_peak_tracker_with_stats.
package tkp_pkg;

    // Input operation codes (s_axis_tuser)
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Result kinds (m_axis_tuser)
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_PEAK = 1'b1;

    // Configuration register indexes
    localparam logic CFG_ROW_LENGTH = 1'b0;
    localparam logic CFG_SKIP_EDGE  = 1'b1;

    localparam logic [16:0] ROW_LENGTH_RST = 17'h10000;
    localparam logic [7:0]  SKIP_EDGE_RST  = 8'd2;

    localparam logic [47:0] CNT_MAX = {48{1'b1}};
    localparam logic [62:0] SQ_MAX  = {63{1'b1}};
    localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

    // One list entry
    typedef struct packed {
        logic signed [31:0] value;
        logic [16:0]        freq;
        logic [16:0]        tpos;
    } entry_t;

    localparam entry_t EMPTY_ENTRY = '{value: 32'h8000_0000, freq: 17'h1FFFF, tpos: 17'h1FFFF};

    // Controls broadcast to every cell
    typedef struct packed {
        logic clear;
        logic insert;
        logic rotate;
    } cell_ctrl_t;

    // Controls for the statistics unit
    typedef struct packed {
        logic clear;
        logic start;
        logic in_win;
        logic finish;
    } stats_ctrl_t;

    typedef struct packed {
        logic [47:0]        count;
        logic signed [63:0] sum;
        logic [62:0]        sumsq;
    } stats_t;

endpackage

[rtl/core/top_k_peak_tracker_with_stats.sv]
// Top-K peak tracker with saturating running statistics.
// Depends on tkp_pkg, tkp_cell and tkp_stats.
//
// Takes one op word at a time. A sample passes through accept and insert,
// square accumulate and result load; a clear through accept and result
// load. A readout emits LIST_DEPTH words, one per cycle while the sink is
// ready, and the next op is taken after the last one is loaded. Square
// accumulate follows the registered 32x32 squarer ahead of the sum of
// squares, and result load is the single output register. The list is a
// chain of LIST_DEPTH cells that insert a sample by compare-and-shift and
// rotate toward the head during readout, so the list is back in place
// after the final word.
module top_k_peak_tracker_with_stats
    import tkp_pkg::*;
#(
    parameter int LIST_DEPTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    // config write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [16:0]  cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // sample_value[31:0], freq_idx[47:32], time_idx[63:48]
    input  logic [1:0]   s_axis_tuser,   // op[1:0]
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [247:0] m_axis_tdata,   // rank[5:0], peak_value[37:6], peak_freq[54:38],
                                         // peak_time[71:55], isolated[72],
                                         // sample_count[120:73], sum_out[184:121],
                                         // sum_squares_out[247:185]
    output logic         m_axis_tuser,   // kind
    output logic         m_axis_tlast    // last
);

    localparam int RW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQ,
        S_ACK,
        S_READ
    } state_t;

    state_t        state_reg;
    logic [RW-1:0] k_reg;
    logic          m_valid_reg;
    logic [247:0]  m_data_reg;
    logic          m_kind_reg;
    logic          m_last_reg;
    logic [16:0]   row_length_reg;
    logic [7:0]    skip_edge_reg;

    logic          s_fire;
    logic          out_free;
    logic          out_load;
    logic          in_win;
    logic [17:0]   tpos_ext;
    entry_t        new_ent;
    cell_ctrl_t    cell_ctrl;
    stats_ctrl_t   stats_ctrl;
    stats_t        stats;

    entry_t                ent [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] valid_vec;
    logic [LIST_DEPTH-1:0] ins_vec;
    logic [LIST_DEPTH-1:0] near_vec;
    logic [LIST_DEPTH-1:0] hi_mask;
    logic                  head_iso;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LENGTH_RST;
            skip_edge_reg  <= SKIP_EDGE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROW_LENGTH: row_length_reg <= cfg_data;
                CFG_SKIP_EDGE:  skip_edge_reg  <= cfg_data[7:0];
                default:        row_length_reg <= row_length_reg;
            endcase
        end
    end

    // Handshakes and window test
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign out_load      = ((state_reg == S_ACK) || (state_reg == S_READ)) && out_free;

    assign tpos_ext = {2'b00, s_axis_tdata[63:48]};
    assign in_win   = (tpos_ext >= {10'd0, skip_edge_reg})
                   && ((tpos_ext + {10'd0, skip_edge_reg}) < {1'b0, row_length_reg});

    assign new_ent.value = s_axis_tdata[31:0];
    assign new_ent.freq  = {1'b0, s_axis_tdata[47:32]};
    assign new_ent.tpos  = {1'b0, s_axis_tdata[63:48]};

    // Controls for cells and statistics
    always_comb
    begin
        cell_ctrl.clear   = s_fire && (s_axis_tuser == OP_CLEAR);
        cell_ctrl.insert  = s_fire && (s_axis_tuser == OP_SAMPLE) && in_win;
        cell_ctrl.rotate  = (state_reg == S_READ) && out_free;
        stats_ctrl.clear  = s_fire && (s_axis_tuser == OP_CLEAR);
        stats_ctrl.start  = s_fire && (s_axis_tuser == OP_SAMPLE);
        stats_ctrl.in_win = in_win;
        stats_ctrl.finish = (state_reg == S_SQ);
    end

    // Peak chain
    genvar j;
    generate
        for (j = 0; j < LIST_DEPTH; j++)
        begin : g_cell
            entry_t prev_ent;
            logic   prev_valid;
            logic   prev_ins;
            entry_t next_ent;
            logic   next_valid;

            if (j == 0)
            begin : g_first
                assign prev_ent   = EMPTY_ENTRY;
                assign prev_valid = 1'b0;
                assign prev_ins   = 1'b0;
            end
            else
            begin : g_rest
                assign prev_ent   = ent[j-1];
                assign prev_valid = valid_vec[j-1];
                assign prev_ins   = ins_vec[j-1];
            end

            if (j == LIST_DEPTH - 1)
            begin : g_wrap
                assign next_ent   = ent[0];
                assign next_valid = valid_vec[0];
            end
            else
            begin : g_next
                assign next_ent   = ent[j+1];
                assign next_valid = valid_vec[j+1];
            end

            tkp_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .new_ent    (new_ent),
                .prev_ent   (prev_ent),
                .prev_valid (prev_valid),
                .prev_ins   (prev_ins),
                .next_ent   (next_ent),
                .next_valid (next_valid),
                .head_ent   (ent[0]),
                .ent        (ent[j]),
                .valid      (valid_vec[j]),
                .ins        (ins_vec[j]),
                .near       (near_vec[j])
            );

            // Cells holding entries already read out (higher ranks)
            assign hi_mask[j] = ((int'(k_reg) + j) >= LIST_DEPTH);
        end
    endgenerate

    assign head_iso = valid_vec[0] && !(|(near_vec & hi_mask));

    // Statistics
    tkp_stats u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (stats_ctrl),
        .sample_value (s_axis_tdata[31:0]),
        .stats        (stats)
    );

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_kind_reg  <= KIND_ACK;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            // word leaves unless a new one is loaded in its place
            if (m_valid_reg && m_axis_tready && !out_load)
                m_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    k_reg <= '0;
                    if (s_fire)
                    begin
                        case (s_axis_tuser)
                            OP_SAMPLE: state_reg <= S_SQ;
                            OP_CLEAR:  state_reg <= S_ACK;
                            OP_READ:   state_reg <= S_READ;
                            default:   state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_ACK;
                end
                S_ACK:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KIND_ACK;
                        m_last_reg  <= 1'b1;
                        m_data_reg  <= {stats.sumsq, stats.sum, stats.count, 1'b0,
                                        EMPTY_ENTRY.tpos, EMPTY_ENTRY.freq,
                                        EMPTY_ENTRY.value, 6'd0};
                        state_reg   <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KIND_PEAK;
                        m_last_reg  <= (k_reg == RW'(LIST_DEPTH - 1));
                        m_data_reg  <= {stats.sumsq, stats.sum, stats.count, head_iso,
                                        ent[0].tpos, ent[0].freq, ent[0].value, 6'(k_reg)};
                        if (k_reg == RW'(LIST_DEPTH - 1))
                            state_reg <= S_IDLE;
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

    // Filled cells form a prefix of the chain whenever it is not rotating
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_READ) |-> (((valid_vec + 1'b1) & valid_vec) == '0))
        else $error("peak chain valid bits are not a prefix");

    // Final readout word ends the readout with tlast
    a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && out_free && k_reg == RW'(LIST_DEPTH - 1))
        |=> (m_axis_tvalid && m_axis_tlast && state_reg == S_IDLE))
        else $error("readout did not end with a last word");

    // Acknowledge is a single statistics word
    a_ack_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACK && out_free)
        |=> (m_axis_tvalid && m_axis_tlast && m_axis_tuser == KIND_ACK))
        else $error("acknowledge word malformed");

    // Chain rotate never coincides with an insert or a clear
    a_rotate_read: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctrl.rotate |-> !(cell_ctrl.insert || cell_ctrl.clear))
        else $error("chain rotate overlaps insert or clear");

endmodule

[rtl/core/tkp_cell.sv]
// One cell of the sorted peak chain: holds one entry and its valid bit.
// Depends on tkp_pkg.
module tkp_cell
    import tkp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_ent,
    input  entry_t     prev_ent,
    input  logic       prev_valid,
    input  logic       prev_ins,
    input  entry_t     next_ent,
    input  logic       next_valid,
    input  entry_t     head_ent,
    output entry_t     ent,
    output logic       valid,
    output logic       ins,
    output logic       near
);

    entry_t ent_reg;
    logic   valid_reg;
    logic signed [17:0] df;
    logic signed [17:0] dt;

    // New sample belongs at or above this cell
    assign ins = !valid_reg || ($signed(new_ent.value) > $signed(ent_reg.value));

    // Neighbor test against the entry at the head of the chain
    always_comb
    begin
        df = $signed({head_ent.freq[16], head_ent.freq}) - $signed({ent_reg.freq[16], ent_reg.freq});
        dt = $signed({head_ent.tpos[16], head_ent.tpos}) - $signed({ent_reg.tpos[16], ent_reg.tpos});
        near = (df >= -18'sd1) && (df <= 18'sd1) && (dt >= -18'sd1) && (dt <= 18'sd1);
    end

    // Clear, shift-down insert, or rotate toward the head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg   <= EMPTY_ENTRY;
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            ent_reg   <= EMPTY_ENTRY;
            valid_reg <= 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (prev_ins)
            begin
                ent_reg   <= prev_ent;
                valid_reg <= prev_valid;
            end
            else if (ins)
            begin
                ent_reg   <= new_ent;
                valid_reg <= 1'b1;
            end
        end
        else if (ctrl.rotate)
        begin
            ent_reg   <= next_ent;
            valid_reg <= next_valid;
        end
    end

    assign ent   = ent_reg;
    assign valid = valid_reg;

endmodule

[rtl/core/tkp_stats.sv]
// Saturating sample counter, sum and sum of squares.
// Depends on tkp_pkg.
module tkp_stats
    import tkp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  stats_ctrl_t        ctrl,
    input  logic signed [31:0] sample_value,
    output stats_t             stats
);

    logic [47:0]        count_reg;
    logic signed [63:0] sum_reg;
    logic [62:0]        sumsq_reg;
    logic [46:0]        sq_reg;
    logic signed [63:0] prod;
    logic signed [64:0] sum_wide;
    logic [63:0]        sumsq_wide;
    logic signed [63:0] sum_next;
    logic [62:0]        sumsq_next;

    // Square and saturating adds
    always_comb
    begin
        prod     = sample_value * sample_value;
        sum_wide = {sum_reg[63], sum_reg} + 65'(sample_value);
        if (sum_wide[64] != sum_wide[63])
            sum_next = sum_wide[64] ? SUM_MIN : SUM_MAX;
        else
            sum_next = sum_wide[63:0];
        sumsq_wide = {1'b0, sumsq_reg} + 64'(sq_reg);
        sumsq_next = sumsq_wide[63] ? SQ_MAX : sumsq_wide[62:0];
    end

    // Count and sum on accept, square added in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            sq_reg    <= '0;
        end
        else if (ctrl.clear)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            sq_reg    <= '0;
        end
        else
        begin
            if (ctrl.start)
            begin
                if (count_reg != CNT_MAX)
                    count_reg <= count_reg + 48'd1;
                if (ctrl.in_win)
                    sum_reg <= sum_next;
                sq_reg <= ctrl.in_win ? prod[62:16] : '0;
            end
            if (ctrl.finish)
                sumsq_reg <= sumsq_next;
        end
    end

    assign stats.count = count_reg;
    assign stats.sum   = sum_reg;
    assign stats.sumsq = sumsq_reg;

endmodule
